// ===== hdl/refcounted_resource_residency_manager_assert.svh =====
// assertion macros for the residency manager
// clocked on clk; RRM_ASSERT is disabled while rst_n is low; no other dependencies
`ifndef REFCOUNTED_RESOURCE_RESIDENCY_MANAGER_ASSERT_SVH
`define REFCOUNTED_RESOURCE_RESIDENCY_MANAGER_ASSERT_SVH
`ifndef SYNTH
// concurrent check on clk, ignored during reset
`define RRM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrm assertion failed");
// concurrent check on clk that also holds during reset
`define RRM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rrm assertion failed");
`else
`define RRM_ASSERT(lbl, prop)
`define RRM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/rrm_pkg.sv =====
// shared types and constants of the residency manager
// no dependencies
package rrm_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int COUNT_BITS  = 16;

    localparam int IDX_W    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ID_W     = 6;
    localparam int FUNC_W   = 2;
    localparam int ACT_W    = 3;
    localparam int ST_W     = 2;
    localparam int PH_W     = 3;
    localparam int OUT_CW   = 16;
    localparam int WIDE_W   = ID_W + IDX_W;

    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

    localparam logic [ST_W-1:0] ST_UNLOADED  = 2'd0;
    localparam logic [ST_W-1:0] ST_LOADING   = 2'd1;
    localparam logic [ST_W-1:0] ST_LOADED    = 2'd2;
    localparam logic [ST_W-1:0] ST_UNLOADING = 2'd3;

    localparam logic [PH_W-1:0] PH_IDLE        = 3'd0;
    localparam logic [PH_W-1:0] PH_LOAD        = 3'd1;
    localparam logic [PH_W-1:0] PH_WAIT_LOAD   = 3'd2;
    localparam logic [PH_W-1:0] PH_DECODE      = 3'd3;
    localparam logic [PH_W-1:0] PH_WAIT_DECODE = 3'd4;
    localparam logic [PH_W-1:0] PH_END         = 3'd5;

    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SELECT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DECODE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    // one table entry as stored in the memory
    typedef struct packed {
        logic [ST_W-1:0]              residency;
        logic [PH_W-1:0]              phase;
        logic signed [COUNT_BITS-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/rrm_req_if.sv =====
// request channel of the residency manager: valid/ready plus item fields
// depends on rrm_pkg
interface rrm_req_if
    import rrm_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0] entry_id;
    logic            load_done;
    logic            decode_done;

    modport source (output valid, func, entry_id, load_done, decode_done, input ready);
    modport sink   (input valid, func, entry_id, load_done, decode_done, output ready);
endinterface

// ===== hdl/rrm_rsp_if.sv =====
// result channel of the residency manager: valid/ready plus result fields
// depends on rrm_pkg
interface rrm_rsp_if
    import rrm_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [ID_W-1:0]          action_entry;
    logic [ST_W-1:0]          entry_state;
    logic                     is_loaded;
    logic signed [OUT_CW-1:0] ref_count;

    modport source (output valid, action, action_entry, entry_state, is_loaded, ref_count,
                    input ready);
    modport sink   (input valid, action, action_entry, entry_state, is_loaded, ref_count,
                    output ready);
endinterface

// ===== hdl/refcounted_resource_residency_manager.sv =====
// top level of the reference-counted resource residency manager
// depends on rrm_pkg, rrm_req_if, rrm_rsp_if, rrm_ram and the assertion header
//
// The table of NUM_ENTRIES entries (residency, load phase, signed saturating
// count) lives in one ram with a registered read. After reset the block runs a
// clearing pass that writes each of the NUM_ENTRIES entries to zero and holds
// req.ready low meanwhile. Each item then goes through two stages: the accept
// cycle issues the ram read (addressed entry, or the next scan pointer on a
// tick), and the second stage, once the result register is free or being taken,
// modifies the entry, writes it back and loads the result register. Throughput is
// one item per cycle while results are taken, because a write to the entry
// being read in the same cycle is forwarded. The loop that sets the clock is
// ram read data -> tick step -> next scan pointer -> ram read address.
`include "refcounted_resource_residency_manager_assert.svh"

module refcounted_resource_residency_manager
    import rrm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rrm_req_if.sink   req,
    rrm_rsp_if.source rsp
);

    // clearing pass
    logic             clr_reg, clr_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;

    // scan pointer
    logic [IDX_W-1:0] scan_reg, scan_next;

    // second stage: item whose ram data is available
    logic              s1_valid_reg, s1_valid_next;
    logic [FUNC_W-1:0] s1_func_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_oor_reg;
    logic              s1_ld_reg;
    logic              s1_dd_reg;
    logic              s1_fwd_reg;
    entry_t            s1_fwd_data_reg;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]         action_reg;
    logic [ID_W-1:0]          action_entry_reg;
    logic [ST_W-1:0]          state_reg;
    logic                     loaded_reg;
    logic signed [OUT_CW-1:0] count_reg;

    // ram ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic acc;
    logic s1_go;
    logic entry_we;

    // request decode
    logic [WIDE_W-1:0] id_wide;
    logic [IDX_W-1:0]  id_idx;
    logic              id_oor;
    logic              req_tick;

    // modify stage
    entry_t            cur;
    entry_t            upd;
    logic [ACT_W-1:0]  act;
    logic              adv;
    logic              cnt_pos;
    logic [WIDE_W-1:0] idx_wide;
    logic signed [COUNT_BITS+OUT_CW-1:0] cnt_ext;

    logic [ACT_W-1:0]         res_action;
    logic [ID_W-1:0]          res_entry;
    logic [ST_W-1:0]          res_state;
    logic signed [OUT_CW-1:0] res_count;

    rrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and stage control
    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clr_reg && (!s1_valid_reg || s1_go);
    assign acc       = req.valid && req.ready;

    assign id_wide  = {{IDX_W{1'b0}}, req.entry_id};
    assign id_idx   = id_wide[IDX_W-1:0];
    assign id_oor   = id_wide >= WIDE_W'(NUM_ENTRIES);
    assign req_tick = req.func == FUNC_TICK;

    // forwarding covers a write to the entry read in the same cycle
    assign cur = s1_fwd_reg ? s1_fwd_data_reg : entry_t'(ram_rdata);

    // entry update and tick step
    always_comb
    begin
        upd     = cur;
        act     = ACT_NONE;
        adv     = 1'b0;
        cnt_pos = cur.count > 0;
        case (s1_func_reg)
            FUNC_TICK:
            begin
                unique case (cur.residency)
                    ST_UNLOADED:
                    begin
                        if (cnt_pos)
                        begin
                            upd.residency = ST_LOADING;
                            upd.phase     = PH_IDLE;
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                    ST_LOADING:
                    begin
                        case (cur.phase)
                            PH_LOAD:
                            begin
                                act       = ACT_READ;
                                upd.phase = PH_WAIT_LOAD;
                            end
                            PH_WAIT_LOAD:
                            begin
                                if (s1_ld_reg)
                                begin
                                    upd.phase = PH_DECODE;
                                end
                            end
                            PH_DECODE:
                            begin
                                act       = ACT_DECODE;
                                upd.phase = PH_WAIT_DECODE;
                            end
                            PH_WAIT_DECODE:
                            begin
                                if (s1_dd_reg)
                                begin
                                    upd.phase = PH_END;
                                end
                            end
                            PH_END:
                            begin
                                upd.residency = ST_LOADED;
                                upd.phase     = PH_IDLE;
                            end
                            // idle and the unused codes start a load
                            default:
                            begin
                                act       = ACT_SELECT;
                                upd.phase = PH_LOAD;
                            end
                        endcase
                    end
                    ST_LOADED:
                    begin
                        if (!cnt_pos)
                        begin
                            upd.residency = ST_UNLOADING;
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (cnt_pos)
                        begin
                            upd.residency = ST_LOADED;
                        end
                        else
                        begin
                            act           = ACT_RELEASE;
                            upd.residency = ST_UNLOADED;
                        end
                    end
                endcase
            end
            FUNC_ACQUIRE:
            begin
                if (cur.count != CNT_MAX)
                begin
                    upd.count = cur.count + COUNT_BITS'(1);
                end
            end
            FUNC_RELEASE:
            begin
                if (cur.count != CNT_MIN)
                begin
                    upd.count = cur.count - COUNT_BITS'(1);
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    // result fields; an entry beyond the table reports all zero
    assign idx_wide = {{ID_W{1'b0}}, s1_idx_reg};
    assign cnt_ext  = {{OUT_CW{upd.count[COUNT_BITS-1]}}, upd.count};

    always_comb
    begin
        if (s1_oor_reg)
        begin
            res_action = ACT_NONE;
            res_entry  = '0;
            res_state  = ST_UNLOADED;
            res_count  = '0;
        end
        else
        begin
            res_action = act;
            res_entry  = (act != ACT_NONE) ? idx_wide[ID_W-1:0] : '0;
            res_state  = upd.residency;
            res_count  = cnt_ext[OUT_CW-1:0];
        end
    end

    // scan pointer moves on only when the scanned entry needs no work
    always_comb
    begin
        scan_next = scan_reg;
        if (s1_go && adv && (s1_func_reg == FUNC_TICK))
        begin
            if (scan_reg == IDX_W'(NUM_ENTRIES - 1))
            begin
                scan_next = '0;
            end
            else
            begin
                scan_next = scan_reg + IDX_W'(1);
            end
        end
    end

    // ram access
    assign entry_we  = s1_go && !s1_oor_reg;
    assign ram_we    = clr_reg || entry_we;
    assign ram_waddr = clr_reg ? clr_idx_reg : s1_idx_reg;
    assign ram_wdata = clr_reg ? entry_t'('0) : upd;
    assign ram_re    = acc;
    assign ram_raddr = req_tick ? scan_next : id_idx;

    // clearing pass after reset
    always_comb
    begin
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        if (clr_reg)
        begin
            if (clr_idx_reg == IDX_W'(NUM_ENTRIES - 1))
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_idx_reg   <= '0;
            scan_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            clr_idx_reg   <= clr_idx_next;
            scan_reg      <= scan_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (acc)
            begin
                s1_fwd_reg <= entry_we && (s1_idx_reg == ram_raddr);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_func_reg     <= req.func;
            s1_idx_reg      <= ram_raddr;
            s1_oor_reg      <= !req_tick && id_oor;
            s1_ld_reg       <= req.load_done;
            s1_dd_reg       <= req.decode_done;
            s1_fwd_data_reg <= upd;
        end
        if (s1_go)
        begin
            action_reg       <= res_action;
            action_entry_reg <= res_entry;
            state_reg        <= res_state;
            loaded_reg       <= res_state == ST_LOADED;
            count_reg        <= res_count;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.action       = action_reg;
    assign rsp.action_entry = action_entry_reg;
    assign rsp.entry_state  = state_reg;
    assign rsp.is_loaded    = loaded_reg;
    assign rsp.ref_count    = count_reg;

    // no item enters while the table is being cleared
    `RRM_ASSERT_ALWAYS(a_no_accept_in_clear, clr_reg |-> !req.ready)
    // a stalled second stage keeps its ram data
    `RRM_ASSERT(a_stall_holds_data, s1_valid_reg && !s1_go |=> $stable(ram_rdata))
    // load commands belong to a loading entry, a release to an unloaded one
    `RRM_ASSERT(a_load_action_state,
        out_valid_reg && (action_reg == ACT_SELECT || action_reg == ACT_READ ||
        action_reg == ACT_DECODE) |-> state_reg == ST_LOADING)
    `RRM_ASSERT(a_release_action_state,
        out_valid_reg && action_reg == ACT_RELEASE |-> state_reg == ST_UNLOADED)

endmodule

// ===== hdl/rrm_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
